// File: src/life_generation_step_defines.svh
// assertion macros for the life generation step block
`ifndef LIFE_GENERATION_STEP_DEFINES_SVH
`define LIFE_GENERATION_STEP_DEFINES_SVH

// property holds at every clock edge out of reset
`define LGS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LGS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lgs_pkg.sv
// shared board constants and row type for the life generation step block
package lgs_pkg;

  localparam int WIDTH  = 64;
  localparam int HEIGHT = 64;
  localparam int AW     = $clog2(HEIGHT);

  typedef logic [WIDTH-1:0] row_t;

endpackage

// File: src/lgs_row_cell.sv
// one row stage of the neighborhood shift chain
module lgs_row_cell (
  input  logic        clk,
  input  logic        shift,
  input  lgs_pkg::row_t din,
  output lgs_pkg::row_t q
);
  import lgs_pkg::*;

  row_t row;

  always_ff @(posedge clk) begin
    if (shift) begin
      row <= din;
    end
  end

  assign q = row;

endmodule

// File: src/lgs_rule.sv
// b3/s23 next-row evaluation for one row from its three-row neighborhood
module lgs_rule (
  input  lgs_pkg::row_t above,
  input  lgs_pkg::row_t here,
  input  lgs_pkg::row_t below,
  input  logic          wrap,
  output lgs_pkg::row_t next_row
);
  import lgs_pkg::*;

  logic [WIDTH+1:0] ext_a;
  logic [WIDTH+1:0] ext_h;
  logic [WIDTH+1:0] ext_b;
  logic [3:0]       n [WIDTH];

  always_comb begin
    // edge columns wrap around or read as dead
    ext_a = {wrap & above[0], above, wrap & above[WIDTH-1]};
    ext_h = {wrap & here[0],  here,  wrap & here[WIDTH-1]};
    ext_b = {wrap & below[0], below, wrap & below[WIDTH-1]};
    for (int x = 0; x < WIDTH; x++) begin
      n[x] = 4'(ext_a[x]) + 4'(ext_a[x+1]) + 4'(ext_a[x+2])
           + 4'(ext_h[x]) + 4'(ext_h[x+2])
           + 4'(ext_b[x]) + 4'(ext_b[x+1]) + 4'(ext_b[x+2]);
      next_row[x] = (n[x] == 4'd3) || (here[x] && (n[x] == 4'd2));
    end
  end

endmodule

// File: src/life_generation_step.sv
// top level of the life generation step block: board memory, sweep control, population count
//
//  channel  direction  signals
//  cfg      in         cfg_valid, cfg_ready, wrap_edges
//  in       in         in_valid, in_ready, kind, row_index, row_bits
//  out      out        out_valid, out_ready, row_data, population
//
// write and no-op items finish as they are taken; a read passes through the read state
// a step fetches one board row per cycle through the single read port of the board
// memory and passes the rows through the shift chain, rule and count stages
// synchronous reset clears control state and the stored edge mode; the board is not cleared
// one item is in work at a time; a finished result waits in a holding register while
// the output register is stalled, and the next item is taken once it has moved on
module life_generation_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        wrap_edges,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  row_index,
  input  logic [63:0] row_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] row_data,
  output logic [12:0] population
);
  import lgs_pkg::*;

`include "life_generation_step_defines.svh"

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  localparam int CW     = $clog2(HEIGHT + 3);
  localparam int NB     = (WIDTH + 7) / 8;
  localparam int SW     = $clog2(WIDTH + 1);
  localparam int POP_W  = 13;

  localparam logic [CW-1:0]    LAST_K  = CW'(HEIGHT + 1);
  localparam logic [CW-1:0]    END_K   = CW'(HEIGHT + 2);
  localparam logic [POP_W-1:0] POP_MAX = {POP_W{1'b1}};

  row_t             mem [HEIGHT];
  row_t             rd_q;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  row_t             wr_data;
  logic             wr_en;

  logic [1:0]       state;
  logic [CW-1:0]    cnt;
  logic             torus;
  logic             in_fire;
  logic             issue;
  logic             rd_need;
  logic             row_ok;
  logic             in_range;

  logic             v1, v2, v3, v4;
  logic             last2, last3, last4;
  logic [CW-1:0]    k1;
  logic [AW-1:0]    r2, r3;
  row_t             first_old;
  row_t             below_in;
  row_t             row_below, row_here, row_above;
  row_t             rule_row;
  row_t             nrow;
  logic [NB*8-1:0]  nrow_pad;
  logic [3:0]       bcnt_next [NB];
  logic [3:0]       bcnt [NB];
  logic [SW-1:0]    bsum;
  logic [POP_W-1:0] acc;
  logic [POP_W:0]   acc_sum;
  logic [POP_W-1:0] acc_sat;

  logic             res_pending;
  logic [63:0]      res_row;
  logic [POP_W-1:0] res_pop;
  logic             load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !res_pending;
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state == S_STEP) && (cnt != END_K);
  assign rd_need   = issue && (cnt != LAST_K);
  assign row_ok    = (32'(row_index) < HEIGHT);
  assign load_out  = res_pending && (!out_valid || out_ready);

  // board memory ports
  always_comb begin
    if (state == S_STEP) begin
      rd_addr = (cnt == '0) ? AW'(HEIGHT - 1) : AW'(cnt - CW'(1));
    end else begin
      rd_addr = AW'(row_index);
    end
    if (v3) begin
      wr_en   = 1'b1;
      wr_addr = r3;
      wr_data = nrow;
    end else begin
      wr_en   = in_fire && (kind == KIND_WRITE) && row_ok;
      wr_addr = AW'(row_index);
      wr_data = row_t'(row_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // neighborhood shift chain: below -> here -> above
  always_comb begin
    if (k1 == '0) begin
      below_in = torus ? rd_q : '0;
    end else if (k1 == LAST_K) begin
      below_in = torus ? first_old : '0;
    end else begin
      below_in = rd_q;
    end
  end

  lgs_row_cell u_cell_below (.clk(clk), .shift(v1), .din(below_in),  .q(row_below));
  lgs_row_cell u_cell_here  (.clk(clk), .shift(v1), .din(row_below), .q(row_here));
  lgs_row_cell u_cell_above (.clk(clk), .shift(v1), .din(row_here),  .q(row_above));

  lgs_rule u_rule (
    .above    (row_above),
    .here     (row_here),
    .below    (row_below),
    .wrap     (torus),
    .next_row (rule_row)
  );

  // population count
  always_comb begin
    nrow_pad = (NB*8)'(nrow);
    for (int b = 0; b < NB; b++) begin
      bcnt_next[b] = '0;
      for (int i = 0; i < 8; i++) begin
        bcnt_next[b] = bcnt_next[b] + 4'(nrow_pad[b*8+i]);
      end
    end
    bsum = '0;
    for (int b = 0; b < NB; b++) begin
      bsum = bsum + SW'(bcnt[b]);
    end
    acc_sum = {1'b0, acc} + (POP_W+1)'(bsum);
    acc_sat = acc_sum[POP_W] ? POP_MAX : acc_sum[POP_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      torus       <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      last2       <= 1'b0;
      last3       <= 1'b0;
      last4       <= 1'b0;
      res_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        torus <= wrap_edges;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (kind)
              KIND_READ: state <= S_READ;
              KIND_STEP: begin
                state <= S_STEP;
                cnt   <= '0;
              end
              default: res_pending <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          state       <= S_IDLE;
          res_pending <= 1'b1;
        end
        S_STEP: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
          if (v4 && last4) begin
            state       <= S_IDLE;
            res_pending <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      v1    <= issue;
      v2    <= v1 && (k1 >= CW'(2));
      v3    <= v2;
      v4    <= v3;
      last2 <= v1 && (k1 == LAST_K);
      last3 <= last2;
      last4 <= last3;
      if (load_out) begin
        res_pending <= 1'b0;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    k1   <= cnt;
    r2   <= AW'(k1 - CW'(2));
    r3   <= r2;
    nrow <= rule_row;
    bcnt <= bcnt_next;
    if (v1 && (k1 == CW'(1))) begin
      first_old <= rd_q;
    end
    if (in_fire) begin
      in_range <= row_ok;
      acc      <= '0;
    end else if (v4) begin
      acc <= acc_sat;
    end
    if (in_fire && (kind != KIND_READ) && (kind != KIND_STEP)) begin
      res_row <= '0;
      res_pop <= '0;
    end else if (state == S_READ) begin
      res_row <= in_range ? 64'(rd_q) : '0;
      res_pop <= '0;
    end else if (v4 && last4) begin
      res_row <= '0;
      res_pop <= acc_sat;
    end
    if (load_out) begin
      row_data   <= res_row;
      population <= res_pop;
    end
  end

  `LGS_CHECK(a_no_rw_clash, (v3 && rd_need) |-> (r3 != rd_addr), "write-back hit fetched row")
  `LGS_CHECK(a_done_in_step, (v4 && last4) |-> (state == S_STEP), "sweep ended outside a step")
  `LGS_CHECK_NEXT(a_hold, res_pending && out_valid && !out_ready, res_pending, "result lost")

endmodule

// File: bench/lgs_tb_pkg.sv
// item kind codes shared by the life generation step testbench files
`timescale 1ns / 100ps
package lgs_tb_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_NOP   = 2'd3
  } item_kind_e;

endpackage

// File: bench/life_step_checker.sv
// checker for the life generation step block: shadow board, expected results and compare
`timescale 1ns / 100ps
module life_step_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        wrap_edges,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  row_index,
  input  logic [63:0] row_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] row_data,
  input  logic [12:0] population,
  output int          outstanding,
  output int          mismatches
);
  import lgs_pkg::*;
  import lgs_tb_pkg::*;

  localparam int POP_CEIL = 8191;

  typedef struct {
    logic [63:0] row_data;
    logic [12:0] population;
  } board_reply_t;

  row_t         shadow_board [HEIGHT];
  logic         torus = 1'b0;
  board_reply_t pending_replies [$];
  int           error_total = 0;

  function automatic logic neighbor_cell(row_t r, int c, logic wrap);
    if (c < 0) begin
      if (!wrap) return 1'b0;
      c = WIDTH - 1;
    end else if (c >= WIDTH) begin
      if (!wrap) return 1'b0;
      c = 0;
    end
    return r[c];
  endfunction

  function automatic row_t evolve_row(row_t above, row_t here, row_t below, logic wrap);
    row_t nxt;
    int   live_nbrs;
    nxt = '0;
    for (int x = 0; x < WIDTH; x++) begin
      live_nbrs = 0;
      for (int dx = -1; dx <= 1; dx++) begin
        live_nbrs += neighbor_cell(above, x + dx, wrap);
        live_nbrs += neighbor_cell(below, x + dx, wrap);
        if (dx != 0) live_nbrs += neighbor_cell(here, x + dx, wrap);
      end
      if (live_nbrs == 3 || (here[x] && live_nbrs == 2)) nxt[x] = 1'b1;
    end
    return nxt;
  endfunction

  function automatic int advance_generation();
    row_t old_rows [HEIGHT];
    row_t above;
    row_t below;
    int   live_total;
    old_rows   = shadow_board;
    live_total = 0;
    for (int r = 0; r < HEIGHT; r++) begin
      if (r == 0) above = torus ? old_rows[HEIGHT-1] : '0;
      else above = old_rows[r-1];
      if (r == HEIGHT - 1) below = torus ? old_rows[0] : '0;
      else below = old_rows[r+1];
      shadow_board[r] = evolve_row(above, old_rows[r], below, torus);
      live_total += $countones(shadow_board[r]);
    end
    return (live_total > POP_CEIL) ? POP_CEIL : live_total;
  endfunction

  function automatic board_reply_t apply_item(item_kind_e k, logic [5:0] idx,
                                              logic [63:0] bits);
    board_reply_t reply;
    reply.row_data   = '0;
    reply.population = '0;
    case (k)
      KIND_WRITE: if (idx < HEIGHT) shadow_board[idx] = bits[WIDTH-1:0];
      KIND_READ:  if (idx < HEIGHT) reply.row_data = shadow_board[idx];
      KIND_STEP:  reply.population = 13'(advance_generation());
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    board_reply_t want;
    if (rst) begin
      torus = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("result transaction with nothing outstanding: row_data %h population %0d",
                 row_data, population);
          error_total++;
        end else begin
          want = pending_replies.pop_front();
          if (row_data !== want.row_data) begin
            $error("row_data expected %h actual %h", want.row_data, row_data);
            error_total++;
          end
          if (population !== want.population) begin
            $error("population expected %0d actual %0d", want.population, population);
            error_total++;
          end
        end
      end
      if (cfg_valid && cfg_ready) torus = wrap_edges;
      if (in_valid && in_ready)
        pending_replies.push_back(apply_item(item_kind_e'(kind), row_index, row_bits));
    end
    outstanding <= pending_replies.size();
    mismatches  <= error_total;
  end

endmodule

// File: bench/testbench.sv
// top of the life generation step testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
  import lgs_pkg::*;
  import lgs_tb_pkg::*;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        wrap_edges = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  kind       = KIND_NOP;
  logic [5:0]  row_index  = '0;
  logic [63:0] row_bits   = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [63:0] row_data;
  logic [12:0] population;
  int          outstanding;
  int          mismatches;

  bit   steady = 1'b0;
  logic wrap_setting = 1'b0;
  int   write_count, read_count, step_count, torus_steps, nop_count, cfg_count;

  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 26);

  life_generation_step uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .wrap_edges (wrap_edges),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_data   (row_data),
    .population (population)
  );

  life_step_checker life_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .wrap_edges  (wrap_edges),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_data    (row_data),
    .population  (population),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  task automatic send_item(item_kind_e k, logic [5:0] idx, logic [63:0] bits);
    if (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    row_index <= idx;
    row_bits  <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (k)
      KIND_WRITE: write_count++;
      KIND_READ:  read_count++;
      KIND_STEP: begin
        step_count++;
        if (wrap_setting) torus_steps++;
      end
      default: nop_count++;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_wrap(logic v);
    drain_results();
    cfg_valid  <= 1'b1;
    wrap_edges <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    wrap_setting = v;
    cfg_count++;
  endtask

  // density levels: empty, sparse, light, half, dense
  function automatic logic [63:0] random_row(int level);
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (level)
      0:       return '0;
      1:       return a & b & c;
      2:       return a & b;
      3:       return a;
      default: return a | b;
    endcase
  endfunction

  task automatic fill_board(int level);
    for (int r = 0; r < HEIGHT; r++) send_item(KIND_WRITE, 6'(r), random_row(level));
  endtask

  task automatic random_phase(int count);
    int pick;
    int burst;
    fill_board($urandom_range(1, 4));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 2) drain_results();
      if (pick < 38) begin
        send_item(KIND_WRITE, 6'($urandom_range(63)), random_row($urandom_range(4)));
      end else if (pick < 68) begin
        send_item(KIND_READ, 6'($urandom_range(63)), {$urandom, $urandom});
      end else if (pick < 88) begin
        burst = $urandom_range(1, 3);
        repeat (burst) send_item(KIND_STEP, 6'($urandom_range(63)), {$urandom, $urandom});
      end else begin
        send_item(KIND_NOP, 6'($urandom_range(63)), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_wrap(1'b0);
    fill_board(0);

    send_item(KIND_WRITE, 6'd5, '1);
    send_item(KIND_READ, 6'd5, '0);
    send_item(KIND_READ, 6'd0, '1);
    send_item(KIND_NOP, 6'd63, '1);
    send_item(KIND_WRITE, 6'd5, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_READ, 6'd5, 64'h5555_5555_5555_5555);
    send_item(KIND_WRITE, 6'd5, '0);
    // blinker in the middle of the board
    send_item(KIND_WRITE, 6'd10, 64'h7 << 20);
    send_item(KIND_STEP, 6'd0, '0);
    send_item(KIND_READ, 6'd9, '0);
    send_item(KIND_READ, 6'd11, '0);
    send_item(KIND_STEP, 6'd63, '1);
    send_item(KIND_READ, 6'd10, '0);
    send_item(KIND_WRITE, 6'd10, '0);
    // corner cells die with dead edges and form a block on the torus
    send_item(KIND_WRITE, 6'd0, 64'h8000_0000_0000_0001);
    send_item(KIND_WRITE, 6'd63, 64'h8000_0000_0000_0001);
    send_item(KIND_STEP, 6'd0, '0);
    set_wrap(1'b1);
    send_item(KIND_WRITE, 6'd0, 64'h8000_0000_0000_0001);
    send_item(KIND_WRITE, 6'd63, 64'h8000_0000_0000_0001);
    send_item(KIND_STEP, 6'd0, '0);
    send_item(KIND_READ, 6'd63, '0);
    send_item(KIND_WRITE, 6'd0, '1);
    send_item(KIND_STEP, 6'd0, '0);
    send_item(KIND_READ, 6'd0, '0);
    send_item(KIND_READ, 6'd1, '0);

    for (int p = 0; p < 4; p++) begin
      set_wrap((p % 2 == 0) ? 1'b0 : 1'b1);
      steady = (p == 2);
      random_phase(150);
    end
    steady = 1'b0;

    drain_results();
    repeat (80) @(posedge clk);
    $display("covered %0d row writes, %0d row reads, %0d generation steps (%0d on the torus)",
             write_count, read_count, step_count, torus_steps);
    $display("plus %0d idle items and %0d edge mode writes, one phase without any stalls",
             nop_count, cfg_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("life_generation_step verification clean");
    end else begin
      $display("life_generation_step verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("life_generation_step verification failed");
    $finish;
  end

endmodule
